/* rtl/core/psr_pkg.sv */
// Package for the polyphase stereo resampler core.
// Holds the sizes, payload types, state codes and arithmetic helpers.
// It depends on nothing else.
package psr_pkg;

   localparam int TAPS       = 16;
   localparam int PHASES     = 32;
   localparam int HISTORY    = 8;

   localparam int SAMPLE_W   = 24;
   localparam int COEF_W     = 18;
   localparam int STEP_W     = 19;
   localparam int INDEX_W    = 9;
   localparam int POS_W      = 24;
   localparam int FRAC_BITS  = 16;
   localparam int MAX_OUT    = 4;
   localparam int NCNT_W     = 3;

   localparam int TAP_AW     = $clog2(TAPS);
   localparam int COEF_DEPTH = PHASES * TAPS;
   localparam int COEF_AW    = $clog2(COEF_DEPTH);
   localparam int PHASE_W    = $clog2(PHASES);
   localparam int PROD_W     = SAMPLE_W + COEF_W;
   localparam int ACC_W      = PROD_W + TAP_AW;
   localparam int Q_W        = ACC_W - FRAC_BITS + 1;

   localparam logic [STEP_W-1:0] STEP_MIN   = STEP_W'(16384);
   localparam logic [STEP_W-1:0] STEP_MAX   = STEP_W'(262144);
   localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);
   localparam logic [POS_W-1:0]  POS_ONE    = POS_W'(1 << FRAC_BITS);
   localparam logic [POS_W-1:0]  POS_RESET  = POS_W'(HISTORY << FRAC_BITS);

   localparam logic signed [ACC_W:0] ROUND_BIAS = (ACC_W + 1)'(1 << (FRAC_BITS - 1));
   localparam logic signed [Q_W-1:0] Q_MAX = Q_W'((1 << (SAMPLE_W - 1)) - 1);
   localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(-(1 << (SAMPLE_W - 1)));

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEF_W-1:0]   coef_type;
   typedef logic        [STEP_W-1:0]   step_type;
   typedef logic        [INDEX_W-1:0]  coef_index_type;

   typedef enum logic [0:0] {
      OP_PUSH  = 1'b0,
      OP_COEF  = 1'b1
   } opcode_type;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_CHECK = 5'b00010,
      S_MAC   = 5'b00100,
      S_DRAIN = 5'b01000,
      S_LOAD  = 5'b10000
   } state_type;

   function automatic logic [TAP_AW-1:0] next_slot(input logic [TAP_AW-1:0] slot);
      if (slot == TAP_AW'(TAPS - 1)) begin
         return '0;
      end
      return slot + TAP_AW'(1);
   endfunction

   // Rounds a Q30.16 sum to nearest with ties upward, then saturates to 24 bits.
   function automatic sample_type round_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W:0]  biased;
      logic signed [Q_W-1:0]  q;
      biased = (ACC_W + 1)'(acc) + ROUND_BIAS;
      q = biased[ACC_W:FRAC_BITS];
      if (q > Q_MAX) begin
         return Q_MAX[SAMPLE_W-1:0];
      end
      if (q < Q_MIN) begin
         return Q_MIN[SAMPLE_W-1:0];
      end
      return q[SAMPLE_W-1:0];
   endfunction

endpackage

/* rtl/core/psr_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// Used for the sample window and the coefficient store; no dependencies.
module psr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/polyphase_stereo_resampler_core.sv */
// Top level of the polyphase stereo resampler core.
// Depends on psr_pkg and on psr_ram for the window and coefficient memories.
//
// Usage:
// The req channel carries one item per handshake. A push item appends a
// left/right sample pair to the window and then produces zero to four output
// frames on the rsp channel; the last of them has rsp_last_of_run set. A
// coefficient item writes one entry of the coefficient memory and produces
// nothing; the block stays idle and ready for the next item.
// The csr port sets the source step (Q3.16 source frames per output frame); it
// must be written only while the block is idle, which the block itself does not enforce.
// Each output frame is computed by one stereo multiply-accumulate pair walking
// the window and coefficient memory read ports one tap per cycle, through the
// states S_CHECK, S_MAC, S_DRAIN and S_LOAD. The block accepts no new item
// until the last frame of a push's run has been loaded into the output register.
// Reset clears the window (through per-slot valid bits, no clearing pass),
// the read position to HISTORY frames and the step to 1.0. Coefficients are
// undefined until written.
// A stalled receiver holds the current frame in the output register; the
// block finishes the next frame and waits, and accepts the next item once the last
// frame of the run is in the output register and the block is back in S_IDLE.
module polyphase_stereo_resampler_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_opcode,
   input  psr_pkg::sample_type     req_sample_left,
   input  psr_pkg::sample_type     req_sample_right,
   input  psr_pkg::coef_index_type req_coef_index,
   input  psr_pkg::coef_type       req_coef_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output psr_pkg::sample_type     rsp_out_left,
   output psr_pkg::sample_type     rsp_out_right,
   output logic                    rsp_last_of_run,
   input  logic                    csr_wr_en,
   input  psr_pkg::step_type       csr_wr_data
);

   import psr_pkg::*;

   state_type                 state_ff, state_in;
   logic [TAP_AW-1:0]         head_ff, head_in;
   logic [TAP_AW-1:0]         slot_ff, slot_in;
   logic [TAP_AW-1:0]         tap_ff, tap_in;
   logic [POS_W-1:0]          pos_ff, pos_in;
   step_type                  step_ff;
   logic [NCNT_W-1:0]         n_ff, n_in;
   logic [PHASE_W-1:0]        phase_ff, phase_in;
   logic [TAPS-1:0]           win_valid_ff;
   logic                      s1_ff, s2_ff, wv_ff;
   logic signed [PROD_W-1:0]  prod_l_ff, prod_r_ff;
   logic signed [ACC_W-1:0]   acc_l_ff, acc_r_ff;
   logic                      rsp_valid_ff;
   sample_type                rsp_left_ff, rsp_right_ff;
   logic                      rsp_last_ff;

   logic                      req_fire, rsp_free, pos_lt_one, last_frame;
   logic                      win_wr, coef_wr, issue, acc_clear, load;
   step_type                  step_use;
   logic [FRAC_BITS+PHASE_W-1:0] phase_prod;
   logic [COEF_AW-1:0]        coef_rd_addr;
   logic [2*SAMPLE_W-1:0]     win_rd_data;
   coef_type                  coef_rd_data;
   sample_type                win_l, win_r;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign pos_lt_one = (pos_ff < POS_ONE);
   assign last_frame = !(pos_lt_one && ((n_ff + NCNT_W'(1)) < NCNT_W'(MAX_OUT)));
   assign phase_prod = (FRAC_BITS + PHASE_W)'(pos_ff[FRAC_BITS-1:0])
                     * (FRAC_BITS + PHASE_W)'(PHASES);
   assign coef_rd_addr = COEF_AW'(phase_ff) * COEF_AW'(TAPS) + COEF_AW'(tap_ff);

   always_comb begin
      if (step_ff < STEP_MIN) begin
         step_use = STEP_MIN;
      end else if (step_ff > STEP_MAX) begin
         step_use = STEP_MAX;
      end else begin
         step_use = step_ff;
      end
   end

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      slot_in   = slot_ff;
      tap_in    = tap_ff;
      pos_in    = pos_ff;
      n_in      = n_ff;
      phase_in  = phase_ff;
      win_wr    = 1'b0;
      coef_wr   = 1'b0;
      issue     = 1'b0;
      acc_clear = 1'b0;
      load      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_opcode == OP_COEF) begin
                  coef_wr = (32'(req_coef_index) < COEF_DEPTH);
               end else begin
                  win_wr   = 1'b1;
                  head_in  = next_slot(head_ff);
                  n_in     = '0;
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (pos_lt_one && (n_ff < NCNT_W'(MAX_OUT))) begin
               phase_in  = phase_prod[FRAC_BITS+PHASE_W-1:FRAC_BITS];
               pos_in    = pos_ff + POS_W'(step_use);
               tap_in    = '0;
               slot_in   = head_ff;
               acc_clear = 1'b1;
               state_in  = S_MAC;
            end else begin
               pos_in   = pos_lt_one ? '0 : (pos_ff - POS_ONE);
               state_in = S_IDLE;
            end
         end
         S_MAC: begin
            issue   = 1'b1;
            tap_in  = tap_ff + TAP_AW'(1);
            slot_in = next_slot(slot_ff);
            if (tap_ff == TAP_AW'(TAPS - 1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!s1_ff && !s2_ff) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            if (rsp_free) begin
               load     = 1'b1;
               n_in     = n_ff + NCNT_W'(1);
               state_in = S_CHECK;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         pos_ff       <= POS_RESET;
         step_ff      <= STEP_RESET;
         n_ff         <= '0;
         win_valid_ff <= '0;
         s1_ff        <= 1'b0;
         s2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         pos_ff   <= pos_in;
         n_ff     <= n_in;
         s1_ff    <= issue;
         s2_ff    <= s1_ff;
         if (csr_wr_en) begin
            step_ff <= csr_wr_data;
         end
         if (win_wr) begin
            win_valid_ff[head_ff] <= 1'b1;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign win_l = wv_ff ? sample_type'(win_rd_data[2*SAMPLE_W-1:SAMPLE_W]) : '0;
   assign win_r = wv_ff ? sample_type'(win_rd_data[SAMPLE_W-1:0]) : '0;

   always_ff @(posedge clock) begin
      slot_ff   <= slot_in;
      tap_ff    <= tap_in;
      phase_ff  <= phase_in;
      wv_ff     <= win_valid_ff[slot_ff];
      prod_l_ff <= win_l * coef_rd_data;
      prod_r_ff <= win_r * coef_rd_data;
      if (acc_clear) begin
         acc_l_ff <= '0;
         acc_r_ff <= '0;
      end else if (s2_ff) begin
         acc_l_ff <= acc_l_ff + ACC_W'(prod_l_ff);
         acc_r_ff <= acc_r_ff + ACC_W'(prod_r_ff);
      end
      if (load) begin
         rsp_left_ff  <= round_sat(acc_l_ff);
         rsp_right_ff <= round_sat(acc_r_ff);
         rsp_last_ff  <= last_frame;
      end
   end

   psr_ram #(
      .WIDTH (2 * SAMPLE_W),
      .DEPTH (TAPS)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (win_wr),
      .wr_addr (head_ff),
      .wr_data ({req_sample_left, req_sample_right}),
      .rd_en   (issue),
      .rd_addr (slot_ff),
      .rd_data (win_rd_data)
   );

   psr_ram #(
      .WIDTH (COEF_W),
      .DEPTH (COEF_DEPTH)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_wr),
      .wr_addr (COEF_AW'(req_coef_index)),
      .wr_data (req_coef_value),
      .rd_en   (issue),
      .rd_addr (coef_rd_addr),
      .rd_data (coef_rd_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_left    = rsp_left_ff;
   assign rsp_out_right   = rsp_right_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for polyphase_stereo_resampler_core.
// Directed rows and random items are checked against a predictor or typed values.
// Depends on psr_pkg and the core RTL only.
module testbench;
   import psr_pkg::*;

   typedef struct packed {
      sample_type left;
      sample_type right;
      logic       last;
   } frame_type;

   typedef struct packed {
      opcode_type     op;
      sample_type     left;
      sample_type     right;
      coef_index_type index;
      coef_type       value;
      logic           typed;
      sample_type     want_left;
      sample_type     want_right;
   } directed_row_type;

   localparam sample_type SAMPLE_MAX = 24'h7FFFFF;
   localparam sample_type SAMPLE_MIN = 24'h800000;
   localparam coef_type   COEF_MAX   = 18'h1FFFF;
   localparam coef_type   COEF_MIN   = 18'h20000;
   localparam coef_type   COEF_HALF  = 18'h08000;
   localparam int N_DIRECTED   = 17;
   localparam int N_SETTINGS   = 7;
   localparam int PHASE_ITEMS  = 52;
   localparam int SETTLE       = 100;
   localparam int QUIET_LIMIT  = 3000;

   logic           clock;
   logic           reset = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_ready;
   logic           req_opcode = 1'b0;
   sample_type     req_sample_left = '0;
   sample_type     req_sample_right = '0;
   coef_index_type req_coef_index = '0;
   coef_type       req_coef_value = '0;
   logic           rsp_valid;
   logic           rsp_ready = 1'b0;
   sample_type     rsp_out_left;
   sample_type     rsp_out_right;
   logic           rsp_last_of_run;
   logic           csr_wr_en = 1'b0;
   step_type       csr_wr_data = '0;

   // Predictor state.
   sample_type        src_left [TAPS];
   sample_type        src_right [TAPS];
   logic [TAP_AW-1:0] src_slot;
   coef_type          kernel [COEF_DEPTH];
   logic [POS_W-1:0]  frame_pos;
   step_type          step_setting;

   frame_type fresh_frames [$];
   frame_type pending_frames [$];
   int        mismatch_count = 0;
   int        quiet_cycles = 0;
   bit        steady = 1'b0;

   polyphase_stereo_resampler_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_sample_left  (req_sample_left),
      .req_sample_right (req_sample_right),
      .req_coef_index   (req_coef_index),
      .req_coef_value   (req_coef_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_left     (rsp_out_left),
      .rsp_out_right    (rsp_out_right),
      .rsp_last_of_run  (rsp_last_of_run),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic sample_type round_to_sample(input longint acc);
      longint q;
      q = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (q > longint'(SAMPLE_MAX)) begin
         q = longint'(SAMPLE_MAX);
      end
      if (q < longint'(SAMPLE_MIN)) begin
         q = longint'(SAMPLE_MIN);
      end
      return sample_type'(q);
   endfunction

   function automatic void resample_pair(input sample_type left, input sample_type right);
      step_type  step;
      longint    acc_left;
      longint    acc_right;
      int        phase;
      int        slot;
      int        t;
      frame_type frame;
      step = step_setting;
      if (step < STEP_MIN) begin
         step = STEP_MIN;
      end
      if (step > STEP_MAX) begin
         step = STEP_MAX;
      end
      src_left[src_slot] = left;
      src_right[src_slot] = right;
      src_slot = src_slot + 1'b1;
      fresh_frames.delete();
      while (frame_pos < POS_ONE && fresh_frames.size() < MAX_OUT) begin
         phase = int'(frame_pos[FRAC_BITS-1 -: PHASE_W]);
         acc_left = 0;
         acc_right = 0;
         for (t = 0; t < TAPS; t++) begin
            slot = (int'(src_slot) + t) % TAPS;
            acc_left += longint'(src_left[slot]) * longint'(kernel[phase * TAPS + t]);
            acc_right += longint'(src_right[slot]) * longint'(kernel[phase * TAPS + t]);
         end
         frame.left = round_to_sample(acc_left);
         frame.right = round_to_sample(acc_right);
         frame.last = 1'b0;
         fresh_frames.push_back(frame);
         frame_pos = frame_pos + POS_W'(step);
      end
      if (fresh_frames.size() > 0) begin
         fresh_frames[fresh_frames.size() - 1].last = 1'b1;
      end
      if (frame_pos >= POS_ONE) begin
         frame_pos = frame_pos - POS_ONE;
      end else begin
         frame_pos = '0;
      end
   endfunction

   function automatic sample_type pick_sample();
      case ($urandom_range(9))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2, 3: return sample_type'(int'($urandom_range(511)) - 256);
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic coef_type pick_coef();
      if ($urandom_range(99) < 12) begin
         return coef_type'($urandom);
      end
      return coef_type'(int'($urandom_range(8191)) - 4096);
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic offer_item(input opcode_type op, input sample_type left,
                             input sample_type right, input coef_index_type index,
                             input coef_type value, input bit typed,
                             input frame_type typed_frame);
      int k;
      while (!steady && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_sample_left <= left;
      req_sample_right <= right;
      req_coef_index <= index;
      req_coef_value <= value;
      do @(posedge clock); while (!req_ready);
      if (op == OP_COEF) begin
         kernel[index] = value;
      end else begin
         resample_pair(left, right);
         if (typed) begin
            pending_frames.push_back(typed_frame);
         end else begin
            for (k = 0; k < fresh_frames.size(); k++) begin
               pending_frames.push_back(fresh_frames[k]);
            end
         end
      end
      @(negedge clock);
   endtask

   task automatic random_item();
      opcode_type op;
      op = ($urandom_range(99) < 80) ? OP_PUSH : OP_COEF;
      offer_item(op, pick_sample(), pick_sample(), coef_index_type'($urandom_range(511)),
                 pick_coef(), 1'b0, '0);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_frames.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_step(input step_type value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      step_setting = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 24);
   end

   always @(posedge clock) begin
      frame_type want;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_frames.size() == 0) begin
            $display("%0t: expected no frame, actual left %0d right %0d last %0d", $time,
                     rsp_out_left, rsp_out_right, rsp_last_of_run);
            mismatch_count++;
         end else begin
            want = pending_frames.pop_front();
            check_field("out_left", want.left, rsp_out_left);
            check_field("out_right", want.right, rsp_out_right);
            check_field("last_of_run", want.last, rsp_last_of_run);
         end
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
      end
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      directed_row_type script [N_DIRECTED];
      step_type         step_plan [N_SETTINGS];
      frame_type        typed_frame;
      int               i;
      int               n;

      for (i = 0; i < TAPS; i++) begin
         src_left[i] = '0;
         src_right[i] = '0;
      end
      for (i = 0; i < COEF_DEPTH; i++) begin
         kernel[i] = '0;
      end
      src_slot = '0;
      frame_pos = POS_RESET;
      step_setting = STEP_RESET;

      // Phase zero holds 0.5 on every tap, so each output is half the window sum.
      // The first eight pairs cancel; later rows probe rounding ties and saturation.
      script = '{
         '{OP_PUSH, SAMPLE_MAX, SAMPLE_MIN, '0, '0, 1'b0, '0, '0},
         '{OP_PUSH, -SAMPLE_MAX, SAMPLE_MAX, '0, '0, 1'b0, '0, '0},
         '{OP_PUSH, SAMPLE_MIN, 24'sd1, '0, '0, 1'b0, '0, '0},
         '{OP_PUSH, SAMPLE_MAX, '0, '0, '0, 1'b0, '0, '0},
         '{OP_PUSH, 24'sd1, '0, '0, '0, 1'b0, '0, '0},
         '{OP_PUSH, '0, '0, '0, '0, 1'b0, '0, '0},
         '{OP_PUSH, '0, '0, '0, '0, 1'b0, '0, '0},
         '{OP_PUSH, '0, '0, '0, '0, 1'b0, '0, '0},
         '{OP_PUSH, 24'sd1, -24'sd1, '0, '0, 1'b1, 24'sd1, '0},
         '{OP_PUSH, 24'sd2, -24'sd4, '0, '0, 1'b1, 24'sd2, -24'sd2},
         '{OP_PUSH, SAMPLE_MAX, SAMPLE_MIN, '0, '0, 1'b0, '0, '0},
         '{OP_PUSH, SAMPLE_MAX, SAMPLE_MIN, '0, '0, 1'b1, SAMPLE_MAX, SAMPLE_MIN},
         '{OP_COEF, SAMPLE_MAX, SAMPLE_MIN, 9'd0, COEF_HALF, 1'b0, '0, '0},
         '{OP_COEF, SAMPLE_MIN, SAMPLE_MAX, 9'd511, COEF_MIN, 1'b0, '0, '0},
         '{OP_COEF, '0, '0, 9'd510, COEF_MAX, 1'b0, '0, '0},
         '{OP_PUSH, SAMPLE_MIN, SAMPLE_MAX, '0, '0, 1'b0, '0, '0},
         '{OP_PUSH, '0, '0, '0, '0, 1'b0, '0, '0}
      };
      step_plan = '{STEP_MIN, '0, STEP_MAX, '1, 19'd98304, '0, '0};
      step_plan[5] = step_type'($urandom_range(STEP_MAX, STEP_MIN));
      step_plan[6] = step_type'($urandom);

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (i = 0; i < COEF_DEPTH; i++) begin
         offer_item(OP_COEF, pick_sample(), pick_sample(), coef_index_type'(i),
                    (i < TAPS) ? COEF_HALF : pick_coef(), 1'b0, '0);
      end

      for (i = 0; i < N_DIRECTED; i++) begin
         typed_frame.left = script[i].want_left;
         typed_frame.right = script[i].want_right;
         typed_frame.last = 1'b1;
         offer_item(script[i].op, script[i].left, script[i].right, script[i].index,
                    script[i].value, script[i].typed, typed_frame);
      end

      for (i = 0; i < N_SETTINGS; i++) begin
         settle();
         write_step(step_plan[i]);
         steady = (i == 4);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            random_item();
         end
      end
      steady = 1'b0;

      settle();
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/psr_pkg.sv
rtl/core/psr_ram.sv
rtl/core/polyphase_stereo_resampler_core.sv
verif/testbench.sv
